// File: hw/rtl/fsp_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// fsp_pkg
// Shared constants, types and tables for the Fibonacci sphere point core.
// ============================================================================
package fsp_pkg;

    localparam int INDEX_BITS_DEF = 16;
    localparam int COORD_BITS_DEF = 16;
    localparam int COUNT_RESET    = 2;

    // Q30 fixed point
    localparam int Q_FRAC = 30;
    localparam logic [31:0] ONE_Q30 = 32'h4000_0000;

    // golden turn fraction in Q32, pi in Q30
    localparam logic [31:0] GOLDEN_TURN = 32'h61C8_8647;
    localparam logic [31:0] PI_Q30      = 32'd3373259426;

    // angle, series term and running sum widths
    localparam int ANG_W  = 31;
    localparam int TERM_W = 32;
    localparam int SUM_W  = 34;

    // pipelined divider / square root / series depth
    localparam int DIV_STEPS    = 32;
    localparam int RAD_W        = 62;
    localparam int ROOT_W       = 31;
    localparam int ROOT_STEPS   = RAD_W / 2;
    localparam int SERIES_STEPS = 8;
    localparam int SERIES_LAT   = 4 * SERIES_STEPS + 1;

    typedef enum logic {
        SERIES_SIN,
        SERIES_COS
    } series_kind_t;

    // divisors of successive series terms and floor(2^32 / divisor)
    localparam logic [8:0] SIN_DIV [1:SERIES_STEPS] =
        '{9'd6, 9'd20, 9'd42, 9'd72, 9'd110, 9'd156, 9'd210, 9'd272};
    localparam logic [8:0] COS_DIV [1:SERIES_STEPS] =
        '{9'd2, 9'd12, 9'd30, 9'd56, 9'd90, 9'd132, 9'd182, 9'd240};
    localparam logic [31:0] SIN_RCP [1:SERIES_STEPS] =
        '{32'd715827882, 32'd214748364, 32'd102261126, 32'd59652323,
          32'd39045157, 32'd27531841, 32'd20452225, 32'd15790320};
    localparam logic [31:0] COS_RCP [1:SERIES_STEPS] =
        '{32'd2147483648, 32'd357913941, 32'd143165576, 32'd76695844,
          32'd47721858, 32'd32537631, 32'd23598721, 32'd17895697};

endpackage

// File: hw/rtl/fsp_series.sv
`timescale 1ns / 1ps
// ============================================================================
// fsp_series
// Pipelined nine-term Taylor series (sine or cosine) in Q30, clamped to
// [0, 1]. Four register stages per term plus one output register.
// ============================================================================
module fsp_series
    import fsp_pkg::*;
#(
    parameter series_kind_t KIND = SERIES_SIN
) (
    input  logic             aclk,
    input  logic             adv,
    input  logic [ANG_W-1:0] t_in,
    output logic [ANG_W-1:0] mag_out
);

    logic [ANG_W-1:0]        t_g    [1:SERIES_STEPS];
    logic [TERM_W-1:0]       term_g [1:SERIES_STEPS];
    logic signed [SUM_W-1:0] sum_g  [1:SERIES_STEPS];
    logic [TERM_W-1:0]       first;
    logic [ANG_W-1:0]        mag_reg;
    logic [ANG_W-1:0]        mag_next;

    assign first = (KIND == SERIES_SIN) ? TERM_W'(t_in) : ONE_Q30;

    for (genvar k = 1; k <= SERIES_STEPS; k++) begin : g_term
        localparam logic [8:0]  DIV = (KIND == SERIES_SIN) ? SIN_DIV[k] : COS_DIV[k];
        localparam logic [31:0] RCP = (KIND == SERIES_SIN) ? SIN_RCP[k] : COS_RCP[k];

        logic [ANG_W-1:0]        t_i;
        logic [TERM_W-1:0]       term_i;
        logic signed [SUM_W-1:0] sum_i;

        logic [TERM_W-1:0]       a_p1_reg, b_p2_reg, c_q0_reg, c_p2_reg;
        logic [ANG_W-1:0]        a_t_reg, b_t_reg, c_t_reg;
        logic signed [SUM_W-1:0] a_sum_reg, b_sum_reg, c_sum_reg;

        logic [TERM_W+ANG_W-1:0] a_prod, b_prod;
        logic [63:0]             c_prod;
        logic [TERM_W+8:0]       d_qd;
        logic [TERM_W-1:0]       d_rem, d_q;
        logic signed [SUM_W-1:0] d_sum;

        if (k == 1) begin : g_first
            assign t_i    = t_in;
            assign term_i = first;
            assign sum_i  = signed'(SUM_W'(first));
        end else begin : g_next
            assign t_i    = t_g[k-1];
            assign term_i = term_g[k-1];
            assign sum_i  = sum_g[k-1];
        end

        // two truncated Q30 products, then divide by the constant divisor
        assign a_prod = (TERM_W+ANG_W)'(term_i) * (TERM_W+ANG_W)'(t_i);
        assign b_prod = (TERM_W+ANG_W)'(a_p1_reg) * (TERM_W+ANG_W)'(a_t_reg);
        assign c_prod = 64'(b_p2_reg) * 64'(RCP);
        // reciprocal estimate is low by at most one
        assign d_qd   = (TERM_W+9)'(c_q0_reg) * (TERM_W+9)'(DIV);
        assign d_rem  = c_p2_reg - d_qd[TERM_W-1:0];
        assign d_q    = c_q0_reg + TERM_W'(d_rem >= TERM_W'(DIV));
        // running sum travels with its term
        assign d_sum  = (k % 2 == 1) ? c_sum_reg - signed'(SUM_W'(d_q))
                                     : c_sum_reg + signed'(SUM_W'(d_q));

        always_ff @(posedge aclk) begin
            if (adv) begin
                a_p1_reg  <= a_prod[Q_FRAC +: TERM_W];
                a_t_reg   <= t_i;
                a_sum_reg <= sum_i;
                b_p2_reg  <= b_prod[Q_FRAC +: TERM_W];
                b_t_reg   <= a_t_reg;
                b_sum_reg <= a_sum_reg;
                c_q0_reg  <= c_prod[63:32];
                c_p2_reg  <= b_p2_reg;
                c_t_reg   <= b_t_reg;
                c_sum_reg <= b_sum_reg;
                term_g[k] <= d_q;
                t_g[k]    <= c_t_reg;
                sum_g[k]  <= d_sum;
            end
        end
    end

    always_comb begin
        if (sum_g[SERIES_STEPS] < 0) begin
            mag_next = '0;
        end else if (sum_g[SERIES_STEPS] > signed'(SUM_W'(ONE_Q30))) begin
            mag_next = ANG_W'(ONE_Q30);
        end else begin
            mag_next = sum_g[SERIES_STEPS][ANG_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            mag_reg <= mag_next;
        end
    end

    assign mag_out = mag_reg;

endmodule

// File: hw/rtl/fsp_root.sv
`timescale 1ns / 1ps
// ============================================================================
// fsp_root
// Pipelined restoring integer square root, one result bit per stage.
// ============================================================================
module fsp_root
    import fsp_pkg::*;
(
    input  logic              aclk,
    input  logic              adv,
    input  logic [RAD_W-1:0]  rad_in,
    output logic [ROOT_W-1:0] root_out
);

    localparam int REM_W = 34;

    logic [REM_W-1:0]  rem_reg [1:ROOT_STEPS];
    logic [ROOT_W-1:0] res_reg [1:ROOT_STEPS];
    logic [RAD_W-1:0]  rad_reg [1:ROOT_STEPS];

    for (genvar s = 1; s <= ROOT_STEPS; s++) begin : g_step
        logic [REM_W-1:0]  rem_i, cur, trial;
        logic [ROOT_W-1:0] res_i;
        logic [RAD_W-1:0]  rad_i;
        logic              take;

        if (s == 1) begin : g_first
            assign rem_i = '0;
            assign res_i = '0;
            assign rad_i = rad_in;
        end else begin : g_next
            assign rem_i = rem_reg[s-1];
            assign res_i = res_reg[s-1];
            assign rad_i = rad_reg[s-1];
        end

        assign cur   = {rem_i[REM_W-3:0], rad_i[RAD_W-1-2*(s-1) -: 2]};
        assign trial = REM_W'({res_i, 2'b01});
        assign take  = cur >= trial;

        always_ff @(posedge aclk) begin
            if (adv) begin
                rem_reg[s] <= take ? cur - trial : cur;
                res_reg[s] <= {res_i[ROOT_W-2:0], take};
                rad_reg[s] <= rad_i;
            end
        end
    end

    assign root_out = res_reg[ROOT_STEPS];

endmodule

// File: hw/rtl/fibonacci_sphere_point_core.sv
`timescale 1ns / 1ps
// ============================================================================
// fibonacci_sphere_point_core
// Unit-sphere coordinates of one point of an n-point Fibonacci lattice.
// ============================================================================
// Takes one point index per cycle while s_ready is high and returns its (x, y, z)
// in signed Q1.(COORD_BITS-1), +1 saturated to the largest positive code. Every
// transfer on the input gives exactly one result; with m_ready held high a new
// index is taken every cycle. The depth comes from the 32-stage bit-per-stage
// divider for y, followed by the 31-stage square root for the ring radius; the
// angle path (golden-angle multiply, nine-term sine and cosine series at four
// stages per term) runs beside it on a delayed copy of the index. The whole
// pipeline advances as one: when a result waits and m_ready is low, every stage
// holds and s_ready drops. The user must write point_count through
// cfg_wr_en/cfg_wr_data only while the core is idle; the core does not enforce
// this. Indices at or above point_count are clamped to the last point.
// ============================================================================
module fibonacci_sphere_point_core
    import fsp_pkg::*;
#(
    parameter int INDEX_BITS = INDEX_BITS_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // point count register
    input  logic                         cfg_wr_en,
    input  logic [INDEX_BITS:0]          cfg_wr_data,
    // index in
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [INDEX_BITS-1:0]        s_point_index,
    // coordinates out
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic signed [COORD_BITS-1:0] m_x_coord,
    output logic signed [COORD_BITS-1:0] m_y_coord,
    output logic signed [COORD_BITS-1:0] m_z_coord
);

    localparam int LW        = INDEX_BITS + 1;
    localparam int DW        = INDEX_BITS + 31;
    // stage positions, counted from the input register
    localparam int R_AT      = 1 + DIV_STEPS + 2 + ROOT_STEPS;
    localparam int IDX_DELAY = R_AT - 2 - SERIES_LAT;
    localparam int OUT_AT    = R_AT + 2;
    // output rounding shifts (x/z are Q60, y is carried as Q32)
    localparam int SHX       = 2 * Q_FRAC - (COORD_BITS - 1);
    localparam int SHY       = Q_FRAC + 2 - (COORD_BITS - 1);

    logic              adv;
    logic [OUT_AT:0]   vld_reg;
    logic [LW-1:0]     cfg_last_reg;

    // ---------------- input stage: clamp index to n-1 ----------------
    logic [INDEX_BITS-1:0] idx0_reg;
    logic [LW-1:0]         last0_reg;

    // global advance: the output register is the last pipeline stage
    assign adv     = !vld_reg[OUT_AT] || m_ready;
    assign s_ready = adv;
    assign m_valid = vld_reg[OUT_AT];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg      <= '0;
            cfg_last_reg <= LW'(COUNT_RESET - 1);
        end else begin
            if (adv) begin
                vld_reg <= {vld_reg[OUT_AT-1:0], s_valid};
            end
            if (cfg_wr_en) begin
                cfg_last_reg <= (cfg_wr_data == '0) ? '0 : cfg_wr_data - LW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            idx0_reg  <= (LW'(s_point_index) > cfg_last_reg) ?
                         cfg_last_reg[INDEX_BITS-1:0] : s_point_index;
            last0_reg <= cfg_last_reg;
        end
    end

    // ---------------- y: q = round(i * 2^31 / (n-1)) ----------------
    // Restoring divider; the part of the dividend above bit 31 is already
    // below the divisor, so 32 quotient bits remain.
    logic [LW-1:0] div_rem_reg  [0:DIV_STEPS];
    logic [31:0]   div_num_reg  [0:DIV_STEPS];
    logic [31:0]   div_q_reg    [0:DIV_STEPS];
    logic [LW-1:0] div_last_reg [0:DIV_STEPS];
    logic [DW-1:0] dividend;

    assign dividend = {idx0_reg, 31'b0} + DW'(last0_reg >> 1);

    always_ff @(posedge aclk) begin
        if (adv) begin
            div_rem_reg[0]  <= LW'(dividend[DW-1:32]);
            div_num_reg[0]  <= dividend[31:0];
            div_q_reg[0]    <= '0;
            div_last_reg[0] <= last0_reg;
        end
    end

    for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_div
        logic [LW:0] cur;
        logic        ge;

        assign cur = {div_rem_reg[k-1], div_num_reg[k-1][DIV_STEPS-k]};
        assign ge  = cur >= {1'b0, div_last_reg[k-1]};

        always_ff @(posedge aclk) begin
            if (adv) begin
                div_rem_reg[k]  <= ge ? LW'(cur - {1'b0, div_last_reg[k-1]}) : LW'(cur);
                div_num_reg[k]  <= div_num_reg[k-1];
                div_q_reg[k]    <= {div_q_reg[k-1][30:0], ge};
                div_last_reg[k] <= div_last_reg[k-1];
            end
        end
    end

    // y = 1 - q in sign/magnitude Q30; a point count of one or zero gives y = +1
    logic [31:0]       q_fin;
    logic              y_neg_reg;
    logic [ANG_W-1:0]  y_mag_reg;
    logic [60:0]       y2_reg;
    logic [ANG_W:0]    y_dly_reg [0:ROOT_STEPS];
    logic [RAD_W-1:0]  rad;
    logic [ROOT_W-1:0] root;
    logic [61:0]       y_sq;

    assign q_fin = (div_last_reg[DIV_STEPS] == '0) ? '0 : div_q_reg[DIV_STEPS];
    assign y_sq  = 62'(y_mag_reg) * 62'(y_mag_reg);

    always_ff @(posedge aclk) begin
        if (adv) begin
            y_neg_reg    <= q_fin > ONE_Q30;
            y_mag_reg    <= (q_fin > ONE_Q30) ? ANG_W'(q_fin - ONE_Q30)
                                              : ANG_W'(ONE_Q30 - q_fin);
            y2_reg       <= y_sq[60:0];
            y_dly_reg[0] <= {y_neg_reg, y_mag_reg};
            for (int i = 1; i <= ROOT_STEPS; i++) begin
                y_dly_reg[i] <= y_dly_reg[i-1];
            end
        end
    end

    // r = floor(sqrt(1 - y^2)) in Q30
    assign rad = (RAD_W'(1) << (2 * Q_FRAC)) - RAD_W'(y2_reg);

    fsp_root u_root (
        .aclk     (aclk),
        .adv      (adv),
        .rad_in   (rad),
        .root_out (root)
    );

    // ---------------- angle path on a delayed index ----------------
    logic [INDEX_BITS-1:0] idx_dly_reg [0:IDX_DELAY-1];
    logic [31:0]           a32_reg;
    logic [INDEX_BITS+31:0] a_prod;
    logic [15:0]           a16;
    logic [46:0]           t_prod;
    logic [ANG_W-1:0]      t_reg;
    logic [1:0]            quad_reg;
    logic [1:0]            quad_dly_reg [0:SERIES_LAT-1];
    logic [ANG_W-1:0]      sin_mag, cos_mag;

    assign a_prod = (INDEX_BITS+32)'(idx_dly_reg[IDX_DELAY-1]) * (INDEX_BITS+32)'(GOLDEN_TURN);
    // 16-bit turn fraction, rounded
    assign a16    = a32_reg[31:16] + 16'(a32_reg[15]);
    // low 14 bits scaled to radians in Q30
    assign t_prod = 47'(a16[13:0]) * 47'(PI_Q30) + (47'(1) << 14);

    always_ff @(posedge aclk) begin
        if (adv) begin
            idx_dly_reg[0] <= idx0_reg;
            for (int i = 1; i < IDX_DELAY; i++) begin
                idx_dly_reg[i] <= idx_dly_reg[i-1];
            end
            a32_reg         <= a_prod[31:0];
            t_reg           <= t_prod[45:15];
            quad_reg        <= a16[15:14];
            quad_dly_reg[0] <= quad_reg;
            for (int i = 1; i < SERIES_LAT; i++) begin
                quad_dly_reg[i] <= quad_dly_reg[i-1];
            end
        end
    end

    fsp_series #(.KIND(SERIES_SIN)) u_sin (
        .aclk    (aclk),
        .adv     (adv),
        .t_in    (t_reg),
        .mag_out (sin_mag)
    );

    fsp_series #(.KIND(SERIES_COS)) u_cos (
        .aclk    (aclk),
        .adv     (adv),
        .t_in    (t_reg),
        .mag_out (cos_mag)
    );

    // ---------------- quadrant mapping and products ----------------
    logic [ANG_W-1:0] sv, cv;
    logic             s_neg, c_neg;
    logic [61:0]      x_prod_reg, z_prod_reg;
    logic             x_neg_reg, z_neg_reg;
    logic [ANG_W:0]   p_y_reg;

    always_comb begin
        case (quad_dly_reg[SERIES_LAT-1])
            2'd0: begin
                sv = sin_mag; s_neg = 1'b0; cv = cos_mag; c_neg = 1'b0;
            end
            2'd1: begin
                sv = cos_mag; s_neg = 1'b0; cv = sin_mag; c_neg = 1'b1;
            end
            2'd2: begin
                sv = sin_mag; s_neg = 1'b1; cv = cos_mag; c_neg = 1'b1;
            end
            default: begin
                sv = cos_mag; s_neg = 1'b1; cv = sin_mag; c_neg = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            x_prod_reg <= 62'(cv) * 62'(root);
            z_prod_reg <= 62'(sv) * 62'(root);
            x_neg_reg  <= c_neg && (cv != '0) && (root != '0);
            z_neg_reg  <= s_neg && (sv != '0) && (root != '0);
            p_y_reg    <= y_dly_reg[ROOT_STEPS];
        end
    end

    // ---------------- rounding and saturation ----------------
    function automatic logic [COORD_BITS-1:0] coord_sat(input logic neg,
                                                        input logic [61:0] mag);
        logic [61:0] lim;
        logic [61:0] m;
        lim = 62'(1) << (COORD_BITS - 1);
        m   = mag;
        if (!neg && m > lim - 62'd1) begin
            m = lim - 62'd1;
        end
        if (neg && m > lim) begin
            m = lim;
        end
        if (neg) begin
            return COORD_BITS'(62'd0 - m);
        end
        return m[COORD_BITS-1:0];
    endfunction

    logic [61:0] x_rnd, y_rnd, z_rnd;
    logic signed [COORD_BITS-1:0] m_x_reg, m_y_reg, m_z_reg;

    assign x_rnd = (x_prod_reg + (62'(1) << (SHX - 1))) >> SHX;
    assign z_rnd = (z_prod_reg + (62'(1) << (SHX - 1))) >> SHX;
    assign y_rnd = ((62'(p_y_reg[ANG_W-1:0]) << 2) + (62'(1) << (SHY - 1))) >> SHY;

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_x_reg <= signed'(coord_sat(x_neg_reg, x_rnd));
            m_y_reg <= signed'(coord_sat(p_y_reg[ANG_W], y_rnd));
            m_z_reg <= signed'(coord_sat(z_neg_reg, z_rnd));
        end
    end

    assign m_x_coord = m_x_reg;
    assign m_y_coord = m_y_reg;
    assign m_z_coord = m_z_reg;

`ifndef SYNTHESIS
    // a stall freezes every valid bit
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> $stable(vld_reg))
        else $error("pipeline valid bits moved during a stall");

    // divider remainder stays below the divisor
    a_div_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[1+DIV_STEPS] && (div_last_reg[DIV_STEPS] != '0)
            |-> div_rem_reg[DIV_STEPS] < div_last_reg[DIV_STEPS])
        else $error("divider remainder out of range");

    // y magnitude never exceeds one, and negative y always has nonzero magnitude
    a_y_range: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[2+DIV_STEPS]
            |-> (y_mag_reg <= ANG_W'(ONE_Q30)) && (!y_neg_reg || (y_mag_reg != '0)))
        else $error("y magnitude out of range");

    // no result right after reset
    a_reset_empty: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_valid)
        else $error("result valid right after reset");
`endif

endmodule
